// ----- src/cenc_pkg.sv -----
// Shared constants, types and code-table functions for the convolutional encoder.
package cenc_pkg;

    localparam int NumLanes    = 8;
    localparam int StateWidth  = 6;
    localparam int GroupWidth  = 3;
    localparam int WordWidth   = 24;
    localparam int CountWidth  = 16;
    localparam int AddrWidth   = 3;
    localparam int DataWidth   = 32;

    localparam logic [AddrWidth-1:0] RateAddr = 3'd0;
    localparam logic [1:0] RateHalf = 2'd2;

    typedef logic [StateWidth-1:0] state_t;
    typedef logic [GroupWidth-1:0] group_t;

    typedef struct packed {
        logic [3:0]            n;
        logic                  three;
        logic [CountWidth-1:0] coded;
    } pack_load_t;

    localparam logic [31:0] RomR3 [16] = '{
        32'h07347043, 32'h61521625, 32'h16256152, 32'h70430734,
        32'h43703407, 32'h25165261, 32'h52612516, 32'h34074370,
        32'h70430734, 32'h16256152, 32'h61521625, 32'h07347043,
        32'h34074370, 32'h52612516, 32'h25165261, 32'h43703407
    };

    localparam logic [31:0] RomR2 [4] = '{
        32'h03122130, 32'h21300312, 32'h30211203, 32'h12033021
    };

    // Encoder state just before bit position pos, from the prior state and the item's bits.
    function automatic state_t window_state(input state_t prev, input logic [7:0] data,
                                            input logic [3:0] pos, input logic half);
        logic [13:0] seq;
        state_t      st;
        for (int k = 0; k < 6; k++) begin
            seq[k] = prev[5-k];
        end
        for (int k = 0; k < 8; k++) begin
            seq[k+6] = data[k];
        end
        for (int j = 0; j < StateWidth; j++) begin
            st[j] = seq[4'(pos + 4'(5 - j))];
        end
        if (half) begin
            st[5:4] = 2'b00;
        end
        return st;
    endfunction

    function automatic group_t rom_group(input logic half, input state_t st, input logic b);
        logic [31:0] word;
        logic [7:0]  byte_sel;
        logic [3:0]  nib;
        word = half ? RomR2[st[3:2]] : RomR3[st[5:2]];
        case (st[1:0])
            2'd0:    byte_sel = word[31:24];
            2'd1:    byte_sel = word[23:16];
            2'd2:    byte_sel = word[15:8];
            default: byte_sel = word[7:0];
        endcase
        nib = b ? byte_sel[3:0] : byte_sel[7:4];
        return half ? {1'b0, nib[1:0]} : nib[2:0];
    endfunction

endpackage

// ----- src/convolutional_encoder_unit.sv -----
// Top level of the convolutional encoder: register port, state, lanes and serializer.
//
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall  | data_byte, bit_count, first_of_call
// output  | out       | out_valid / out_stall| out_byte, last_byte, coded_bits
// config  | in        | APB write/read       | code_rate at address 0
//
// An item is encoded by eight lanes in the cycle it is accepted; its 2 or 3 bytes then
// leave one per cycle while out_stall is low, so the output port sets the rate.
// The next item is accepted in the cycle the last byte leaves.
// Reset sets rate 1/2 and clears the encoder state and the coded-bit count.
// A stalled output holds its byte and stalls the input once the item buffer is full.
module convolutional_encoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cenc_pkg::AddrWidth-1:0]  paddr,
    input  logic [cenc_pkg::DataWidth-1:0]  pwdata,
    output logic [cenc_pkg::DataWidth-1:0]  prdata,
    output logic                            pready,
    input  logic [7:0]                      data_byte,
    input  logic [3:0]                      bit_count,
    input  logic                            first_of_call,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic [7:0]                      out_byte,
    output logic                            last_byte,
    output logic [15:0]                     coded_bits,
    output logic                            out_valid,
    input  logic                            out_stall
);
    import cenc_pkg::*;

    logic [1:0]            rate_reg;
    state_t                state_reg, state_next;
    logic [CountWidth-1:0] total_reg, total_next;
    logic                  half, cfg_wr, accept, free, load;
    logic [3:0]            n_eff;
    logic [4:0]            n_coded;
    group_t                groups [NumLanes];
    pack_load_t            load_info;

    assign half   = (rate_reg == RateHalf);
    assign cfg_wr = psel && penable && pwrite && (paddr == RateAddr);
    assign pready = 1'b1;
    assign prdata = (paddr == RateAddr) ? DataWidth'(rate_reg) : '0;

    assign in_stall = !free;
    assign accept   = in_valid && free;
    assign n_eff    = bit_count[3] ? 4'd8 : {1'b0, bit_count[2:0]};
    assign load     = accept && (n_eff != 4'd0);

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        cenc_lane #(
            .LaneIdx(g)
        ) u_lane (
            .prev_state(state_reg),
            .data      (data_byte),
            .half      (half),
            .group_out (groups[g])
        );
    end

    always_comb
    begin
        n_coded    = half ? 5'({n_eff, 1'b0}) : 5'({n_eff, 1'b0}) + 5'(n_eff);
        state_next = state_reg;
        total_next = total_reg;
        if (accept) begin
            if (first_of_call) begin
                total_next = '0;
            end
            if (n_eff != 4'd0) begin
                state_next = window_state(state_reg, data_byte, n_eff, half);
                total_next = total_next + CountWidth'(n_coded);
            end
        end
        load_info.n     = n_eff;
        load_info.three = !half;
        load_info.coded = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rate_reg  <= RateHalf;
            state_reg <= '0;
            total_reg <= '0;
        end else begin
            total_reg <= total_next;
            if (cfg_wr) begin
                rate_reg  <= pwdata[1:0];
                state_reg <= '0;
            end else begin
                state_reg <= state_next;
            end
        end
    end

    cenc_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_info (load_info),
        .groups    (groups),
        .free      (free),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .coded_bits(coded_bits),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

// ----- src/cenc_lane.sv -----
// One encoder lane: coded group for a single bit position of the item.
module cenc_lane #(
    parameter int LaneIdx = 0
) (
    input  cenc_pkg::state_t prev_state,
    input  logic [7:0]       data,
    input  logic             half,
    output cenc_pkg::group_t group_out
);
    import cenc_pkg::*;

    state_t st;

    always_comb
    begin
        st        = window_state(prev_state, data, 4'(LaneIdx), half);
        group_out = rom_group(half, st, data[LaneIdx]);
    end

endmodule

// ----- src/cenc_pack.sv -----
// Merge of lane groups into the coded word and byte serializer for the output channel.
module cenc_pack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  cenc_pkg::pack_load_t  load_info,
    input  cenc_pkg::group_t      groups [cenc_pkg::NumLanes],
    output logic                  free,
    output logic [7:0]            out_byte,
    output logic                  last_byte,
    output logic [15:0]           coded_bits,
    output logic                  out_valid,
    input  logic                  out_stall
);
    import cenc_pkg::*;

    logic [WordWidth-1:0]  word_reg, word_next;
    logic [1:0]            left_reg, left_next;
    logic                  valid_reg, valid_next;
    logic [CountWidth-1:0] coded_reg, coded_next;
    logic [WordWidth-1:0]  acc;
    logic                  send;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NumLanes; i++) begin
            if (4'(i) < load_info.n) begin
                if (load_info.three) begin
                    acc = acc | (WordWidth'(groups[i]) << ((7 - i) * 3));
                end else begin
                    acc = acc | (WordWidth'(groups[i]) << ((7 - i) * 2 + 8));
                end
            end
        end
    end

    assign send       = valid_reg && !out_stall;
    assign free       = !valid_reg || (send && left_reg == 2'd1);
    assign out_byte   = word_reg[WordWidth-1 -: 8];
    assign last_byte  = (left_reg == 2'd1);
    assign coded_bits = coded_reg;
    assign out_valid  = valid_reg;

    always_comb
    begin
        word_next  = word_reg;
        left_next  = left_reg;
        valid_next = valid_reg;
        coded_next = coded_reg;
        if (send) begin
            word_next = word_reg << 8;
            left_next = left_reg - 2'd1;
            if (left_reg == 2'd1) begin
                valid_next = 1'b0;
            end
        end
        if (load) begin
            word_next  = acc;
            left_next  = load_info.three ? 2'd3 : 2'd2;
            valid_next = 1'b1;
            coded_next = load_info.coded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        coded_reg <= coded_next;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the convolutional encoder unit: directed rows, random phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HalfPeriod   = 5;
    localparam int ResetCycles  = 12;
    localparam int SettleCycles = 8;
    localparam int PhaseItems   = 31;

    localparam logic [cenc_pkg::AddrWidth-1:0] SpareAddr = 3'd4;

    localparam logic [31:0] RateHalfWord     = 32'd2;
    localparam logic [31:0] RateHalfHighJunk = 32'hFFFF_FFFE;
    localparam logic [31:0] RateThird        = 32'd3;
    localparam logic [31:0] RateThirdAlt0    = 32'd0;
    localparam logic [31:0] RateThirdAlt1    = 32'd1;

    typedef struct packed {
        logic        set_rate;
        logic [31:0] rate_word;
        logic [7:0]  data;
        logic [3:0]  cnt;
        logic        first;
        logic        typed;
        logic [1:0]  typed_n;
        logic [23:0] typed_word;
        logic [15:0] typed_coded;
    } step_row_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last;
        logic [15:0] coded;
    } coded_byte_t;

    localparam logic [31:0] CodeTableK7 [16] = '{
        32'h07347043, 32'h61521625, 32'h16256152, 32'h70430734,
        32'h43703407, 32'h25165261, 32'h52612516, 32'h34074370,
        32'h70430734, 32'h16256152, 32'h61521625, 32'h07347043,
        32'h34074370, 32'h52612516, 32'h25165261, 32'h43703407
    };

    localparam logic [31:0] CodeTableK5 [4] = '{
        32'h03122130, 32'h21300312, 32'h30211203, 32'h12033021
    };

    // set_rate, rate_word, data, cnt, first, typed, typed_n, typed_word, typed_coded
    localparam step_row_t DirectedRows [23] = '{
        '{1'b0, RateHalfWord,  8'h00, 4'd8,  1'b1, 1'b1, 2'd2, 24'h000000, 16'd16},
        '{1'b0, RateHalfWord,  8'h00, 4'd0,  1'b1, 1'b1, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'h00, 4'd1,  1'b0, 1'b1, 2'd2, 24'h000000, 16'd2},
        '{1'b0, RateHalfWord,  8'h01, 4'd1,  1'b0, 1'b1, 2'd2, 24'h00C000, 16'd4},
        '{1'b0, RateHalfWord,  8'hFF, 4'd8,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'h80, 4'd8,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'h55, 4'd15, 1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'hAA, 4'd9,  1'b1, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'h3C, 4'd0,  1'b0, 1'b1, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'h7F, 4'd7,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateHalfWord,  8'hFE, 4'd4,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b1, RateThird,     8'h00, 4'd8,  1'b1, 1'b1, 2'd3, 24'h000000, 16'd24},
        '{1'b0, RateThird,     8'h01, 4'd1,  1'b0, 1'b1, 2'd3, 24'hE00000, 16'd27},
        '{1'b0, RateThird,     8'hFF, 4'd8,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateThird,     8'h00, 4'd8,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateThird,     8'hC3, 4'd12, 1'b1, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateThird,     8'h5A, 4'd3,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateThird,     8'hA5, 4'd0,  1'b1, 1'b1, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateThird,     8'h96, 4'd8,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b1, RateThirdAlt0, 8'h00, 4'd8,  1'b1, 1'b1, 2'd3, 24'h000000, 16'd24},
        '{1'b0, RateThirdAlt0, 8'hF0, 4'd8,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b1, RateThirdAlt1, 8'h0F, 4'd8,  1'b1, 1'b0, 2'd0, 24'h000000, 16'd0},
        '{1'b0, RateThirdAlt1, 8'h33, 4'd2,  1'b0, 1'b0, 2'd0, 24'h000000, 16'd0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [cenc_pkg::AddrWidth-1:0]  paddr;
    logic [cenc_pkg::DataWidth-1:0]  pwdata;
    logic [cenc_pkg::DataWidth-1:0]  prdata;
    logic                            pready;
    logic [7:0]                      data_byte;
    logic [3:0]                      bit_count;
    logic                            first_of_call;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      out_byte;
    logic                            last_byte;
    logic [15:0]                     coded_bits;
    logic                            out_valid;
    logic                            out_stall = 1'b0;

    logic [1:0]  rate_reg;
    logic [5:0]  pred_state;
    logic [15:0] coded_total;
    coded_byte_t expected_bytes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int bytes_checked = 0;
    int reg_writes    = 0;

    convolutional_encoder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .data_byte     (data_byte),
        .bit_count     (bit_count),
        .first_of_call (first_of_call),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .out_byte      (out_byte),
        .last_byte     (last_byte),
        .coded_bits    (coded_bits),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

    always #(HalfPeriod) clk = ~clk;

    function automatic logic [3:0] code_group(input logic half, input logic [5:0] st,
                                              input logic b);
        logic [31:0] word;
        int          sh;
        logic [3:0]  nib;
        word = half ? CodeTableK5[st[3:2]] : CodeTableK7[st[5:2]];
        sh = (3 - int'(st[1:0])) * 8 + (b ? 0 : 4);
        nib = 4'(word >> sh);
        return nib & (half ? 4'h3 : 4'h7);
    endfunction

    // Encodes one item into the packed word; returns the number of output bytes.
    function automatic int encode_item(input logic [7:0] data, input logic [3:0] cnt,
                                       input logic first, output logic [23:0] word);
        logic       half;
        int         r;
        int         n;
        logic       b;
        logic [3:0] g;
        half = (rate_reg == cenc_pkg::RateHalf);
        r = half ? 2 : 3;
        word = '0;
        if (first)
        begin
            coded_total = '0;
        end
        n = (cnt > 4'd8) ? 8 : int'(cnt);
        if (n == 0)
        begin
            return 0;
        end
        for (int i = 0; i < n; i++)
        begin
            b = data[i];
            g = code_group(half, pred_state, b);
            pred_state = {pred_state[4:0], b};
            if (half)
            begin
                pred_state[5:4] = 2'b00;
            end
            word = word | (24'(g) << ((7 - i) * r));
        end
        coded_total = coded_total + 16'(n * r);
        return r;
    endfunction

    function automatic step_row_t random_row();
        step_row_t row;
        int        pick;
        row = '0;
        row.data = 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            row.cnt = 4'd0;
        end
        else if (pick == 1)
        begin
            row.cnt = 4'($urandom_range(9, 15));
        end
        else
        begin
            row.cnt = 4'($urandom_range(1, 8));
        end
        row.first = ($urandom_range(0, 7) == 0);
        return row;
    endfunction

    task automatic send_item(input step_row_t row);
        logic [23:0] word;
        int          n;
        logic [15:0] coded;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'($urandom);
            @(negedge clk);
        end
        data_byte <= row.data;
        bit_count <= row.cnt;
        first_of_call <= row.first;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        n = encode_item(row.data, row.cnt, row.first, word);
        coded = coded_total;
        if (row.typed)
        begin
            n = row.typed_n;
            word = row.typed_word;
            coded = row.typed_coded;
        end
        for (int k = 0; k < n; k++)
        begin
            expected_bytes.push_back(coded_byte_t'{8'(word >> ((n - 1 - k) * 8)),
                                                   k == n - 1, coded});
        end
        items_sent++;
        @(negedge clk);
    endtask

    // Zero-count items leave nothing to wait for, so keep waiting for a settle period after the last byte.
    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic reg_write(input logic [cenc_pkg::AddrWidth-1:0] addr,
                             input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
    endtask

    task automatic reg_read(input logic [cenc_pkg::AddrWidth-1:0] addr,
                            output logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_rate(input logic [31:0] value);
        logic [31:0] readback;
        drain_outputs();
        reg_write(cenc_pkg::RateAddr, value);
        rate_reg = value[1:0];
        pred_state = '0;
        reg_read(cenc_pkg::RateAddr, readback);
        if (readback !== 32'(rate_reg))
        begin
            mismatches++;
            $display("%0t: code_rate readback expected %h got %h", $time,
                     32'(rate_reg), readback);
        end
    endtask

    task automatic run_phase(input logic [31:0] value, input int send_pct, input int recv_pct,
                             input int items, input logic spare);
        set_rate(value);
        if (spare)
        begin
            reg_write(SpareAddr, $urandom);
        end
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (items) send_item(random_row());
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_out
        coded_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected output byte %h last %b count %0d", $time,
                         out_byte, last_byte, coded_bits);
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (out_byte !== want.out_byte)
                begin
                    mismatches++;
                    $display("%0t: out_byte expected %h got %h", $time,
                             want.out_byte, out_byte);
                end
                if (last_byte !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last_byte expected %b got %b", $time,
                             want.last, last_byte);
                end
                if (coded_bits !== want.coded)
                begin
                    mismatches++;
                    $display("%0t: coded_bits expected %0d got %0d", $time,
                             want.coded, coded_bits);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        step_row_t row;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        data_byte = '0;
        bit_count = '0;
        first_of_call = 1'b0;
        in_valid = 1'b0;
        rate_reg = cenc_pkg::RateHalf;
        pred_state = '0;
        coded_total = '0;
        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 87;
        foreach (DirectedRows[i])
        begin
            row = DirectedRows[i];
            if (row.set_rate)
            begin
                set_rate(row.rate_word);
            end
            send_item(row);
        end

        run_phase(RateThird,        22, 87, PhaseItems, 1'b0);
        run_phase(RateThirdAlt0,    22, 87, PhaseItems, 1'b0);
        run_phase(RateHalfHighJunk, 87, 22, PhaseItems, 1'b0);
        run_phase(RateThirdAlt1,    87, 22, PhaseItems, 1'b0);
        run_phase(RateHalfWord,      0,  0, PhaseItems, 1'b0);
        run_phase(RateThird,         0,  0, PhaseItems, 1'b1);
        drain_outputs();

        $display("Run covered %0d items and %0d register writes across both code rates,",
                 items_sent, reg_writes);
        $display("%0d output bytes checked under input and output stalls.",
                 bytes_checked);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
